>>> design/brb_pkg.sv
// Package for the byte ring buffer: store depth, field widths, opcodes
// and the packed beat types of the input and result channels.
// No dependencies.
`timescale 1ns / 1ps

package brb_pkg;

    localparam int DEPTH = 4096;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int LEN_W = 13;
    localparam int CNT_W = 13;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] write_byte;
        logic       end_of_transfer;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       read_byte;
        logic             accepted;
        logic [CNT_W-1:0] transfer_count;
        logic [LEN_W-1:0] read_space;
        logic [LEN_W-1:0] write_space;
    } out_item_t;

endpackage

>>> design/byte_ring_buffer.sv
// Top level of the byte ring buffer: a byte FIFO over a circular store whose
// length in use is set by a register. Depends on brb_pkg.
//
//   channel   signals                       direction   beat
//   in        in_valid, in_stall, in_data   sink        in_item_t
//   out       out_valid, out_stall, out_data source     out_item_t
//   cfg       cfg_valid, cfg_ready, cfg_data sink       buffer length
//
// Each beat's result appears in the output register on the next cycle, so
// one beat per cycle is sustained while no result waits unread. The store
// is a single memory with one write and one registered read port per cycle.
// Reset clears the indices, fill level and transfer count; the store keeps
// whatever it holds. The input stalls only while a result waits unread.
`timescale 1ns / 1ps

module byte_ring_buffer
    import brb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [LEN_W-1:0] cfg_data
);

    logic [LEN_W-1:0] length_reg;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [LEN_W-1:0] level_reg, level_next;
    logic [CNT_W-1:0] moved_reg, moved_next;
    logic             out_valid_reg;
    out_item_t        result_reg, result_next;
    logic             rd_sel_reg;
    logic [7:0]       rd_data_reg;
    logic [7:0]       mem [DEPTH];

    logic             accept;
    logic             cfg_write;
    logic [LEN_W-1:0] len;
    logic             wr_ok;
    logic             rd_ok;
    logic             moved;
    logic [CNT_W-1:0] moved_inc;
    logic [LEN_W-1:0] wr_idx_inc;
    logic [LEN_W-1:0] rd_idx_inc;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign len = (length_reg > LEN_RESET) ? LEN_RESET : length_reg;

    assign wr_ok = accept && (in_data.opcode == OP_WRITE)
                   && (len != '0) && (level_reg < len);
    assign rd_ok = accept && (in_data.opcode == OP_READ)
                   && (len != '0) && (level_reg != '0);
    assign moved = wr_ok || rd_ok;

    assign wr_idx_inc = LEN_W'(wr_idx_reg) + LEN_W'(1);
    assign rd_idx_inc = LEN_W'(rd_idx_reg) + LEN_W'(1);
    assign moved_inc  = (moved && moved_reg != CNT_MAX) ? moved_reg + CNT_W'(1) : moved_reg;

    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        level_next  = level_reg;
        moved_next  = moved_reg;
        result_next = result_reg;
        if (wr_ok)
        begin
            wr_idx_next = (wr_idx_inc == len) ? '0 : wr_idx_inc[IDX_W-1:0];
            level_next  = level_reg + LEN_W'(1);
        end
        if (rd_ok)
        begin
            rd_idx_next = (rd_idx_inc == len) ? '0 : rd_idx_inc[IDX_W-1:0];
            level_next  = level_reg - LEN_W'(1);
        end
        result_next.read_byte = 8'd0;
        result_next.accepted  = moved;
        case (in_data.opcode)
            OP_WRITE, OP_READ:
            begin
                result_next.transfer_count = moved_inc;
                moved_next = in_data.end_of_transfer ? '0 : moved_inc;
            end
            OP_CLEAR:
            begin
                wr_idx_next = '0;
                rd_idx_next = '0;
                level_next  = '0;
                moved_next  = '0;
                result_next.transfer_count = '0;
            end
            default:
            begin
                result_next.transfer_count = moved_reg;
            end
        endcase
        result_next.read_space  = level_next;
        result_next.write_space = len - level_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= LEN_RESET;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            level_reg     <= '0;
            moved_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                length_reg <= cfg_data;
                wr_idx_reg <= '0;
                rd_idx_reg <= '0;
                level_reg  <= '0;
                moved_reg  <= '0;
            end
            else if (accept)
            begin
                wr_idx_reg <= wr_idx_next;
                rd_idx_reg <= rd_idx_next;
                level_reg  <= level_next;
                moved_reg  <= moved_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
            rd_sel_reg <= rd_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[wr_idx_reg] <= in_data.write_byte;
        end
        if (rd_ok)
        begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    always_comb
    begin
        out_data = result_reg;
        out_data.read_byte = rd_sel_reg ? rd_data_reg : 8'd0;
    end

    assign out_valid = out_valid_reg;

    // The fill level never exceeds the length in use.
    assert property (@(posedge clk) disable iff (!rst_n) level_reg <= len)
        else $error("fill level above buffer length");

    // Both indices stay inside the slots in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        (len == '0) || (wr_idx_reg < len && rd_idx_reg < len))
        else $error("index outside buffer length");

    // An accepted beat always leaves a result in the output register.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> out_valid_reg)
        else $error("accepted beat produced no result");

    // A refused or non-moving beat never returns a byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data.accepted) |-> (out_data.read_byte == 8'd0))
        else $error("byte returned without acceptance");

    // After an accepted beat, read and write spaces add up to the length in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_write) |=> (out_data.read_space + out_data.write_space == $past(len)))
        else $error("spaces do not add up to length");

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for byte_ring_buffer: directed beats from a table,
// then random phases over many buffer lengths.
// Depends on brb_pkg and byte_ring_buffer.
`timescale 1ns / 1ps

module tb_top;
    import brb_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        bit               is_cfg;
        logic [LEN_W-1:0] length;
        in_item_t         beat;
        bit               known;
        out_item_t        want;
    } dir_row_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_stall;
    out_item_t        out_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_data;

    logic [7:0]       ring_store [DEPTH];
    int unsigned      wr_idx;
    int unsigned      rd_idx;
    bit               last_wr;
    int unsigned      moved;
    logic [LEN_W-1:0] buf_len;

    out_item_t   expected_results [$];
    dir_row_t    dir_rows [$];
    int unsigned errors;
    int unsigned results_seen;
    bit          quiet;

    byte_ring_buffer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("byte_ring_buffer verification failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void clear_indices();
        wr_idx  = 0;
        rd_idx  = 0;
        last_wr = 1'b0;
        moved   = 0;
    endfunction

    function automatic int unsigned fill_level(int unsigned len);
        if (len == 0)
            return 0;
        if (wr_idx > rd_idx)
            return wr_idx - rd_idx;
        if (wr_idx < rd_idx)
            return len + wr_idx - rd_idx;
        return last_wr ? len : 0;
    endfunction

    function automatic int unsigned next_index(int unsigned idx, int unsigned len);
        return (idx + 1 >= len) ? 0 : idx + 1;
    endfunction

    function automatic out_item_t predict_result(in_item_t beat);
        out_item_t   r;
        int unsigned len;
        int unsigned level;
        len = (buf_len > DEPTH) ? DEPTH : buf_len;
        r = '0;
        if (beat.opcode == OP_CLEAR)
        begin
            clear_indices();
        end
        else if (beat.opcode == OP_UNUSED)
        begin
            r.transfer_count = CNT_W'(moved);
        end
        else
        begin
            level = fill_level(len);
            if (beat.opcode == OP_WRITE)
            begin
                if (len != 0 && level < len)
                begin
                    ring_store[wr_idx] = beat.write_byte;
                    wr_idx = next_index(wr_idx, len);
                    last_wr = 1'b1;
                    r.accepted = 1'b1;
                end
            end
            else if (len != 0 && level > 0)
            begin
                r.read_byte = ring_store[rd_idx];
                rd_idx = next_index(rd_idx, len);
                last_wr = 1'b0;
                r.accepted = 1'b1;
            end
            if (r.accepted && moved < CNT_MAX)
                moved++;
            r.transfer_count = CNT_W'(moved);
            if (beat.end_of_transfer)
                moved = 0;
        end
        level = fill_level(len);
        r.read_space  = LEN_W'(level);
        r.write_space = LEN_W'(len - level);
        return r;
    endfunction

    function automatic void dir_cfg(int unsigned len);
        dir_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.length = LEN_W'(len);
        dir_rows.push_back(row);
    endfunction

    function automatic void dir_beat(logic [1:0] op, logic [7:0] b, logic eot);
        dir_row_t row;
        row = '{default: '0};
        row.beat = '{opcode: op, write_byte: b, end_of_transfer: eot};
        dir_rows.push_back(row);
    endfunction

    function automatic void dir_known(logic [1:0] op, logic [7:0] b, logic eot,
                                      logic [7:0] rb, logic acc, int unsigned cnt,
                                      int unsigned rs, int unsigned ws);
        dir_row_t row;
        row = '{default: '0};
        row.beat  = '{opcode: op, write_byte: b, end_of_transfer: eot};
        row.known = 1'b1;
        row.want  = '{read_byte: rb, accepted: acc, transfer_count: CNT_W'(cnt),
                      read_space: LEN_W'(rs), write_space: LEN_W'(ws)};
        dir_rows.push_back(row);
    endfunction

    function automatic void note_failure(string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endfunction

    task automatic send_beat(input in_item_t beat, input bit known, input out_item_t want);
        int        gap;
        out_item_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = predict_result(beat);
        expected_results.push_back(known ? want : predicted);
        @(negedge clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] len);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        buf_len = len;
        clear_indices();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver side: random stall pattern plus one long hold-off that starts
    // while a result waits and the sender is offering the next beat.
    initial
    begin
        int stall_left;
        int run_left;
        bit held;
        stall_left = 0;
        run_left   = 0;
        held       = 1'b0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && results_seen >= 400 && in_valid && out_valid)
            begin
                held = 1'b1;
                stall_left = 200;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (run_left > 0)
            begin
                out_stall <= 1'b0;
                run_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                run_left   = $urandom_range(0, 8);
                stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        out_item_t want;
        out_item_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got = out_data;
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    note_failure($sformatf("result %0d arrived with none expected",
                                           results_seen));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.read_byte !== want.read_byte || got.accepted !== want.accepted ||
                        got.transfer_count !== want.transfer_count ||
                        got.read_space !== want.read_space ||
                        got.write_space !== want.write_space)
                        note_failure($sformatf({"result %0d: expected rb=%02h acc=%0d ",
                            "cnt=%0d rs=%0d ws=%0d, got rb=%02h acc=%0d cnt=%0d rs=%0d ws=%0d"},
                            results_seen, want.read_byte, want.accepted,
                            want.transfer_count, want.read_space, want.write_space,
                            got.read_byte, got.accepted, got.transfer_count,
                            got.read_space, got.write_space));
                end
            end
        end
    end

    initial
    begin
        in_item_t    beat;
        int unsigned done_items;
        int unsigned phase_items;
        int unsigned pick;
        bit          filling;
        bit          to_write;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        errors       = 0;
        results_seen = 0;
        quiet        = 1'b0;
        buf_len      = LEN_RESET;
        clear_indices();

        dir_known(OP_READ,  8'h00, 1'b0, 8'h00, 1'b0, 0, 0, 4096);
        dir_known(OP_WRITE, 8'hFF, 1'b0, 8'h00, 1'b1, 1, 1, 4095);
        dir_known(OP_WRITE, 8'h00, 1'b1, 8'h00, 1'b1, 2, 2, 4094);
        dir_known(OP_UNUSED, 8'hFF, 1'b1, 8'h00, 1'b0, 0, 2, 4094);
        dir_known(OP_READ,  8'h00, 1'b0, 8'hFF, 1'b1, 1, 1, 4095);
        dir_known(OP_CLEAR, 8'hFF, 1'b1, 8'h00, 1'b0, 0, 0, 4096);
        dir_cfg(0);
        dir_known(OP_WRITE, 8'hA5, 1'b0, 8'h00, 1'b0, 0, 0, 0);
        dir_known(OP_READ,  8'h00, 1'b1, 8'h00, 1'b0, 0, 0, 0);
        dir_cfg(8191);
        dir_known(OP_WRITE, 8'h5A, 1'b0, 8'h00, 1'b1, 1, 1, 4095);
        dir_known(OP_UNUSED, 8'h00, 1'b0, 8'h00, 1'b0, 1, 1, 4095);
        dir_cfg(1);
        dir_known(OP_WRITE, 8'h81, 1'b0, 8'h00, 1'b1, 1, 1, 0);
        dir_known(OP_WRITE, 8'h7E, 1'b1, 8'h00, 1'b0, 1, 1, 0);
        dir_known(OP_READ,  8'h00, 1'b0, 8'h81, 1'b1, 1, 0, 1);
        dir_known(OP_READ,  8'h00, 1'b1, 8'h00, 1'b0, 1, 0, 1);
        dir_cfg(3);
        dir_beat(OP_WRITE, 8'h11, 1'b0);
        dir_beat(OP_WRITE, 8'h22, 1'b0);
        dir_beat(OP_WRITE, 8'h33, 1'b0);
        dir_beat(OP_WRITE, 8'h44, 1'b0);
        dir_beat(OP_READ,  8'h00, 1'b0);
        dir_beat(OP_WRITE, 8'h55, 1'b1);
        dir_beat(OP_READ,  8'h00, 1'b0);
        dir_beat(OP_READ,  8'h00, 1'b0);
        dir_beat(OP_READ,  8'h00, 1'b0);
        dir_beat(OP_READ,  8'h00, 1'b1);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                write_length(dir_rows[i].length);
            else
                send_beat(dir_rows[i].beat, dir_rows[i].known, dir_rows[i].want);
        end

        done_items = 0;
        while (done_items < 850)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                write_length(LEN_W'($urandom_range(1, 8)));
            else if (pick < 75)
                write_length(LEN_W'($urandom_range(9, 64)));
            else if (pick < 83)
                write_length(LEN_W'($urandom_range(65, 4095)));
            else if (pick < 87)
                write_length(LEN_W'(4096));
            else if (pick < 91)
                write_length('0);
            else if (pick < 95)
                write_length(LEN_W'($urandom_range(4097, 8190)));
            else
                write_length(LEN_W'(8191));
            quiet = ($urandom_range(0, 5) == 0);
            phase_items = $urandom_range(20, 80);
            filling = 1'b1;
            repeat (phase_items)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                begin
                    beat.opcode = OP_CLEAR;
                end
                else if (pick < 6)
                begin
                    beat.opcode = OP_UNUSED;
                end
                else
                begin
                    if ($urandom_range(0, 9) == 0)
                        filling = !filling;
                    to_write = ($urandom_range(0, 9) < 8);
                    if (!filling)
                        to_write = !to_write;
                    beat.opcode = to_write ? OP_WRITE : OP_READ;
                end
                beat.write_byte      = 8'($urandom);
                beat.end_of_transfer = ($urandom_range(0, 9) == 0);
                send_beat(beat, 1'b0, '0);
                done_items++;
            end
            quiet = 1'b0;
        end

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (5) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("byte_ring_buffer verification clean");
        else
            $display("byte_ring_buffer verification failed");
        $finish;
    end

endmodule

>>> sim.f
design/brb_pkg.sv
design/byte_ring_buffer.sv
sim/tb_top.sv
